>>> design/fmau_pkg.sv
// Shared types and constants for the motor feedback angle unwrapper.
// Used by the front, queue, back and top-level modules; no dependencies.
package fmau_pkg;

  // Encoder counts in one rotor turn
  localparam int COUNTS_PER_TURN = 8191;

  // Field widths
  localparam int ANG_W   = 16;
  localparam int STEP_W  = 18;
  localparam int SPD6_W  = 19;
  localparam int GEAR_W  = 17;
  localparam int PROD_W  = 36;
  localparam int SPDP_W  = 37;
  localparam int SPEED_W = 35;
  localparam int POS_W   = 48;
  localparam int CNT_W   = 32;

  // Gear register value after reset (ratio of one in Q16)
  localparam logic [GEAR_W-1:0] GEAR_RESET = 17'h10000;

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_STATUS = 2'd0,
    FUNC_ABS    = 2'd1,
    FUNC_ZERO   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  // Classified frame as it travels through the queue
  typedef struct packed {
    func_e                     kind;
    logic signed [ANG_W-1:0]   angle;
    logic signed [STEP_W-1:0]  step;
    logic signed [SPD6_W-1:0]  speed6;
    logic signed [15:0]        current;
    logic signed [7:0]         temp;
    logic signed [31:0]        turns;
    logic signed [15:0]        abs_angle;
  } item_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic s1_valid;
    logic pop;
  } back_stat_t;

endpackage

>>> design/motor_feedback_angle_unwrapper_top.sv
// Top level of the motor feedback angle unwrapper: gear register and wiring.
// Depends on fmau_pkg, fmau_front, fmau_fifo and fmau_back.
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o  | func_i, byte0_i .. byte6_i
//   cfg     | cfg_valid_i / cfg_ready_o| inv_gear_ratio_i
//   out     | out_valid_o / out_ready_i| rotor_angle_o .. absolute_angle_o
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes through the queue write, the multiply stage and the accumulate stage to the outputs.
// The accumulate register for shaft position sets the per-item rate.
// Reset is asynchronous; the gear ratio returns to 1.0 (65536 in Q16).
// An output stall holds the result; the two-entry queue and the multiply
// stage keep accepting until they fill.
module motor_feedback_angle_unwrapper_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          func_i,
  input  logic [7:0]                          byte0_i,
  input  logic [7:0]                          byte1_i,
  input  logic [7:0]                          byte2_i,
  input  logic [7:0]                          byte3_i,
  input  logic [7:0]                          byte4_i,
  input  logic [7:0]                          byte5_i,
  input  logic [7:0]                          byte6_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fmau_pkg::GEAR_W-1:0]         inv_gear_ratio_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [15:0]                  rotor_angle_o,
  output logic signed [fmau_pkg::SPEED_W-1:0] shaft_speed_o,
  output logic signed [15:0]                  motor_current_o,
  output logic signed [7:0]                   motor_temp_o,
  output logic signed [fmau_pkg::POS_W-1:0]   shaft_position_o,
  output logic [fmau_pkg::CNT_W-1:0]          frames_seen_o,
  output logic signed [31:0]                  turn_count_o,
  output logic signed [15:0]                  absolute_angle_o
);
  import fmau_pkg::*;

  logic [GEAR_W-1:0]  gear_q;
  logic               push, full, head_valid;
  item_t              push_item, head_item;
  logic [FIFO_CW-1:0] fifo_cnt;
  back_stat_t         bk_stat;

  // Hold the gear ratio register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q <= GEAR_RESET;
    end else if (cfg_valid_i) begin
      gear_q <= inv_gear_ratio_i;
    end
  end

  fmau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .byte0_i    (byte0_i),
    .byte1_i    (byte1_i),
    .byte2_i    (byte2_i),
    .byte3_i    (byte3_i),
    .byte4_i    (byte4_i),
    .byte5_i    (byte5_i),
    .byte6_i    (byte6_i),
    .full_i     (full),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .item_o     (push_item)
  );

  fmau_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .pop_i        (bk_stat.pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_item),
    .cnt_o        (fifo_cnt)
  );

  fmau_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head_item),
    .gear_i           (gear_q),
    .out_ready_i      (out_ready_i),
    .stat_o           (bk_stat),
    .out_valid_o      (out_valid_o),
    .rotor_angle_o    (rotor_angle_o),
    .shaft_speed_o    (shaft_speed_o),
    .motor_current_o  (motor_current_o),
    .motor_temp_o     (motor_temp_o),
    .shaft_position_o (shaft_position_o),
    .frames_seen_o    (frames_seen_o),
    .turn_count_o     (turn_count_o),
    .absolute_angle_o (absolute_angle_o)
  );

  // Status frame count moves by at most one per cycle
  a_frames_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frames_seen_o == $past(frames_seen_o)) ||
    (frames_seen_o == $past(frames_seen_o) + 1'b1))
    else $error("frames_seen jumped by more than one");

  // A new result only comes out of the multiply stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_stat.s1_valid))
    else $error("result appeared with empty multiply stage");

  // The back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> (fifo_cnt != '0))
    else $error("pop from empty queue");

  // A push without a pop grows the queue by one item
  a_fifo_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !bk_stat.pop) |=> (fifo_cnt == $past(fifo_cnt) + 1'b1))
    else $error("queue occupancy lost an item");

endmodule

>>> design/fmau_front.sv
// Front end: accepts frames, unpacks the bytes and unwraps the rotor angle step.
// Depends on fmau_pkg.
module fmau_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           func_i,
  input  logic [7:0]           byte0_i,
  input  logic [7:0]           byte1_i,
  input  logic [7:0]           byte2_i,
  input  logic [7:0]           byte3_i,
  input  logic [7:0]           byte4_i,
  input  logic [7:0]           byte5_i,
  input  logic [7:0]           byte6_i,
  input  logic                 full_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output fmau_pkg::item_t      item_o
);
  import fmau_pkg::*;

  localparam logic signed [STEP_W-1:0] TURN = STEP_W'(COUNTS_PER_TURN);
  localparam logic signed [STEP_W-1:0] NEG_TURN = -TURN;

  logic signed [ANG_W-1:0]  prev_angle_q, prev_angle_d;
  logic signed [ANG_W-1:0]  angle;
  logic signed [ANG_W:0]    diff;
  logic signed [STEP_W-1:0] diff_x, diff2, step;
  logic signed [15:0]       raw_speed;
  logic signed [SPD6_W-1:0] raw_x;
  func_e                    kind;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign kind       = func_e'(func_i);

  // Unwrap the step by one turn when it reaches half a turn
  assign angle  = $signed({byte0_i, byte1_i});
  assign diff   = $signed({angle[ANG_W-1], angle}) -
                  $signed({prev_angle_q[ANG_W-1], prev_angle_q});
  assign diff_x = STEP_W'(diff);
  assign diff2  = {diff, 1'b0};

  always_comb begin
    if (diff2 <= NEG_TURN) begin
      step = diff_x + TURN;
    end else if (diff2 >= TURN) begin
      step = diff_x - TURN;
    end else begin
      step = diff_x;
    end
  end

  // Scale raw speed by six with shifts
  assign raw_speed = $signed({byte2_i, byte3_i});
  assign raw_x     = SPD6_W'(raw_speed);

  always_comb begin
    item_o.kind      = kind;
    item_o.angle     = angle;
    item_o.step      = step;
    item_o.speed6    = (raw_x <<< 2) + (raw_x <<< 1);
    item_o.current   = $signed({byte4_i, byte5_i});
    item_o.temp      = $signed(byte6_i);
    item_o.turns     = $signed({byte0_i, byte1_i, byte2_i, byte3_i});
    item_o.abs_angle = $signed({byte4_i, byte5_i});
  end

  // Track the last status angle
  always_comb begin
    prev_angle_d = prev_angle_q;
    if (push_o && kind == FUNC_STATUS) begin
      prev_angle_d = angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_angle_q <= '0;
    end else begin
      prev_angle_q <= prev_angle_d;
    end
  end

endmodule

>>> design/fmau_fifo.sv
// Short queue that decouples the front end from the back end.
// Depends on fmau_pkg.
module fmau_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  fmau_pkg::item_t             item_i,
  input  logic                        pop_i,
  output logic                        full_o,
  output logic                        head_valid_o,
  output fmau_pkg::item_t             head_o,
  output logic [fmau_pkg::FIFO_CW-1:0] cnt_o
);
  import fmau_pkg::*;

  localparam logic [FIFO_AW-1:0] LAST = FIFO_AW'(FIFO_DEPTH - 1);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign cnt_o        = cnt_q;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> design/fmau_back.sv
// Back end: gear-ratio multiplies, position accumulation and the held result.
// Depends on fmau_pkg.
module fmau_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  fmau_pkg::item_t                   head_i,
  input  logic [fmau_pkg::GEAR_W-1:0]       gear_i,
  input  logic                              out_ready_i,
  output fmau_pkg::back_stat_t              stat_o,
  output logic                              out_valid_o,
  output logic signed [15:0]                rotor_angle_o,
  output logic signed [fmau_pkg::SPEED_W-1:0] shaft_speed_o,
  output logic signed [15:0]                motor_current_o,
  output logic signed [7:0]                 motor_temp_o,
  output logic signed [fmau_pkg::POS_W-1:0] shaft_position_o,
  output logic [fmau_pkg::CNT_W-1:0]        frames_seen_o,
  output logic signed [31:0]                turn_count_o,
  output logic signed [15:0]                absolute_angle_o
);
  import fmau_pkg::*;

  // Multiply stage
  logic                       s1_valid_q;
  item_t                      s1_item_q;
  logic signed [PROD_W-1:0]   pos_prod_q, pos_prod_d;
  logic signed [SPEED_W-1:0]  spd_q;
  logic signed [SPDP_W-1:0]   spd_full;
  logic signed [STEP_W-1:0]   gear_s;
  logic                       s1_ready, out_adv, pop;

  // Result state
  logic                       out_valid_q;
  logic signed [15:0]         angle_q, angle_d;
  logic signed [SPEED_W-1:0]  speed_q, speed_d;
  logic signed [15:0]         current_q, current_d;
  logic signed [7:0]          temp_q, temp_d;
  logic signed [POS_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]           frames_q, frames_d;
  logic signed [31:0]         turns_q, turns_d;
  logic signed [15:0]         abs_q, abs_d;

  assign out_adv  = !out_valid_q || out_ready_i;
  assign s1_ready = !s1_valid_q || out_adv;
  assign pop      = head_valid_i && s1_ready;

  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.pop      = pop;

  // Scale step and speed by the reciprocal gear ratio
  assign gear_s     = $signed({1'b0, gear_i});
  assign pos_prod_d = head_i.step * gear_s;
  assign spd_full   = head_i.speed6 * gear_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_item_q  <= head_i;
      pos_prod_q <= pos_prod_d;
      spd_q      <= spd_full[SPEED_W-1:0];
    end
  end

  // Apply the item to the held values
  always_comb begin
    angle_d   = angle_q;
    speed_d   = speed_q;
    current_d = current_q;
    temp_d    = temp_q;
    pos_d     = pos_q;
    frames_d  = frames_q;
    turns_d   = turns_q;
    abs_d     = abs_q;
    if (out_adv && s1_valid_q) begin
      unique case (s1_item_q.kind)
        FUNC_STATUS: begin
          angle_d   = s1_item_q.angle;
          speed_d   = spd_q;
          current_d = s1_item_q.current;
          temp_d    = s1_item_q.temp;
          pos_d     = pos_q + POS_W'(pos_prod_q);
          frames_d  = frames_q + 1'b1;
        end
        FUNC_ABS: begin
          turns_d = s1_item_q.turns;
          abs_d   = s1_item_q.abs_angle;
        end
        FUNC_ZERO: begin
          pos_d = '0;
        end
        FUNC_RSVD: begin
          pos_d = pos_q;
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      angle_q     <= '0;
      speed_q     <= '0;
      current_q   <= '0;
      temp_q      <= '0;
      pos_q       <= '0;
      frames_q    <= '0;
      turns_q     <= '0;
      abs_q       <= '0;
    end else begin
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      angle_q   <= angle_d;
      speed_q   <= speed_d;
      current_q <= current_d;
      temp_q    <= temp_d;
      pos_q     <= pos_d;
      frames_q  <= frames_d;
      turns_q   <= turns_d;
      abs_q     <= abs_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rotor_angle_o    = angle_q;
  assign shaft_speed_o    = speed_q;
  assign motor_current_o  = current_q;
  assign motor_temp_o     = temp_q;
  assign shaft_position_o = pos_q;
  assign frames_seen_o    = frames_q;
  assign turn_count_o     = turns_q;
  assign absolute_angle_o = abs_q;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for motor_feedback_angle_unwrapper_top.
// Holds a bit-exact predictor of the decoded feedback and drives all three channels.
// Depends on fmau_pkg and the design sources only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmau_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_FRAMES = 175;

  // One decoded result as it leaves the block
  typedef struct packed {
    logic signed [15:0]        rotor_angle;
    logic signed [SPEED_W-1:0] shaft_speed;
    logic signed [15:0]        motor_current;
    logic signed [7:0]         motor_temp;
    logic signed [POS_W-1:0]   shaft_position;
    logic [CNT_W-1:0]          frames_seen;
    logic signed [31:0]        turn_count;
    logic signed [15:0]        absolute_angle;
  } feedback_t;

  // Track the decoder state and hold the feedback each accepted frame must produce
  class shaft_tracker;
    logic [GEAR_W-1:0]         gear;
    logic signed [15:0]        prev_angle;
    logic signed [15:0]        angle;
    logic signed [SPEED_W-1:0] speed;
    logic signed [15:0]        current;
    logic signed [7:0]         temp;
    logic [POS_W-1:0]          position;
    logic [CNT_W-1:0]          status_frames;
    logic signed [31:0]        turns;
    logic signed [15:0]        abs_angle;
    feedback_t                 due_results[$];
    int                        mismatches;
    int                        checked;

    function new();
      gear          = GEAR_RESET;
      prev_angle    = '0;
      angle         = '0;
      speed         = '0;
      current       = '0;
      temp          = '0;
      position      = '0;
      status_frames = '0;
      turns         = '0;
      abs_angle     = '0;
      mismatches    = 0;
      checked       = 0;
    endfunction

    function void set_gear(logic [GEAR_W-1:0] g);
      gear = g;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Advance the state by one frame; bytes are byte0 in the top bits down to byte6
    function void note_frame(func_e kind, logic [55:0] data);
      longint step;
      feedback_t r;
      case (kind)
        FUNC_STATUS: begin
          step = longint'($signed(data[55:40])) - longint'(prev_angle);
          // unwrap by one turn at most
          if (2 * step <= -COUNTS_PER_TURN) step = step + COUNTS_PER_TURN;
          else if (2 * step >= COUNTS_PER_TURN) step = step - COUNTS_PER_TURN;
          position      = POS_W'(longint'(position) + step * longint'(gear));
          speed         = SPEED_W'(6 * longint'($signed(data[39:24])) * longint'(gear));
          status_frames = status_frames + 1;
          angle         = data[55:40];
          prev_angle    = data[55:40];
          current       = data[23:8];
          temp          = data[7:0];
        end
        FUNC_ABS: begin
          turns     = data[55:24];
          abs_angle = data[23:8];
        end
        FUNC_ZERO: position = '0;
        default: ;
      endcase
      r.rotor_angle    = angle;
      r.shaft_speed    = speed;
      r.motor_current  = current;
      r.motor_temp     = temp;
      r.shaft_position = position;
      r.frames_seen    = status_frames;
      r.turn_count     = turns;
      r.absolute_angle = abs_angle;
      due_results.push_back(r);
    endfunction

    function void diff(string field, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result with the oldest pending one
    function void check_result(feedback_t got);
      feedback_t want;
      if (due_results.size() == 0) begin
        $error("result arrived with no frame pending");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      diff("rotor_angle", want.rotor_angle, got.rotor_angle);
      diff("shaft_speed", want.shaft_speed, got.shaft_speed);
      diff("motor_current", want.motor_current, got.motor_current);
      diff("motor_temp", want.motor_temp, got.motor_temp);
      diff("shaft_position", want.shaft_position, got.shaft_position);
      diff("frames_seen", want.frames_seen, got.frames_seen);
      diff("turn_count", want.turn_count, got.turn_count);
      diff("absolute_angle", want.absolute_angle, got.absolute_angle);
    endfunction
  endclass

  logic                       clk_i            = 1'b0;
  logic                       rst_ni           = 1'b0;
  logic                       in_valid_i       = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 func_i           = FUNC_STATUS;
  logic [7:0]                 byte0_i          = '0;
  logic [7:0]                 byte1_i          = '0;
  logic [7:0]                 byte2_i          = '0;
  logic [7:0]                 byte3_i          = '0;
  logic [7:0]                 byte4_i          = '0;
  logic [7:0]                 byte5_i          = '0;
  logic [7:0]                 byte6_i          = '0;
  logic                       cfg_valid_i      = 1'b0;
  logic                       cfg_ready_o;
  logic [GEAR_W-1:0]          inv_gear_ratio_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i      = 1'b0;
  logic signed [15:0]         rotor_angle_o;
  logic signed [SPEED_W-1:0]  shaft_speed_o;
  logic signed [15:0]         motor_current_o;
  logic signed [7:0]          motor_temp_o;
  logic signed [POS_W-1:0]    shaft_position_o;
  logic [CNT_W-1:0]           frames_seen_o;
  logic signed [31:0]         turn_count_o;
  logic signed [15:0]         absolute_angle_o;

  shaft_tracker book = new();

  bit          steady;       // no random idling on either side while set; a hold request still stalls
  bit          hold_req;     // ask the receiver for one long stall
  logic [15:0] sent_angle;   // last status angle offered
  int          frames_sent;
  int          gear_writes;
  int          cycles;

  motor_feedback_angle_unwrapper_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .byte0_i          (byte0_i),
    .byte1_i          (byte1_i),
    .byte2_i          (byte2_i),
    .byte3_i          (byte3_i),
    .byte4_i          (byte4_i),
    .byte5_i          (byte5_i),
    .byte6_i          (byte6_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .inv_gear_ratio_i (inv_gear_ratio_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .rotor_angle_o    (rotor_angle_o),
    .shaft_speed_o    (shaft_speed_o),
    .motor_current_o  (motor_current_o),
    .motor_temp_o     (motor_temp_o),
    .shaft_position_o (shaft_position_o),
    .frames_seen_o    (frames_seen_o),
    .turn_count_o     (turn_count_o),
    .absolute_angle_o (absolute_angle_o)
  );

  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one frame, with a random gap first unless steady, and hold it until accepted
  task automatic send_frame(input func_e kind, input logic [55:0] data);
    if (!steady) begin
      while ($urandom_range(99) < 23) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    func_i     <= kind;
    {byte0_i, byte1_i, byte2_i, byte3_i, byte4_i, byte5_i, byte6_i} <= data;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_frame(kind, data);
    if (kind == FUNC_STATUS) sent_angle = data[55:40];
    frames_sent++;
  endtask

  // Drop the input and wait until every pending result has come back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_gear(input logic [GEAR_W-1:0] g);
    cfg_valid_i      <= 1'b1;
    inv_gear_ratio_i <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    book.set_gear(g);
    gear_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // Take results, check them, and pick the next ready value
  initial begin : result_sink
    int        hold_left;
    feedback_t got;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{rotor_angle_o, shaft_speed_o, motor_current_o, motor_temp_o,
                shaft_position_o, frames_seen_o, turn_count_o, absolute_angle_o};
        book.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= (hold_left == 0);
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin : stimulus
    logic [GEAR_W-1:0] gear_plan [6];
    logic [15:0]       next_angle;
    int                jump;
    int                pick;

    gear_plan[0] = 17'd1;
    gear_plan[1] = 17'd0;
    gear_plan[2] = 17'h1FFFF;
    gear_plan[3] = GEAR_W'($urandom_range(65536, 1));
    gear_plan[4] = GEAR_RESET;
    gear_plan[5] = GEAR_W'($urandom);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset gear ratio
    send_frame(FUNC_STATUS, {16'h0000, 16'h0000, 16'h0000, 8'h00});
    // just under half a turn: no unwrap
    send_frame(FUNC_STATUS, {16'd4095, 16'h7FFF, 16'h7FFF, 8'h7F});
    // just over half a turn forward: unwrap backward
    send_frame(FUNC_STATUS, {16'd8191, 16'h8000, 16'h8000, 8'h80});
    send_frame(FUNC_STATUS, {16'd4096, 16'hFFFF, 16'hFFFF, 8'hFF});
    // just over half a turn backward: unwrap forward
    send_frame(FUNC_STATUS, {16'd0, 16'h0001, 16'h0001, 8'h01});
    send_frame(FUNC_STATUS, {16'h7FFF, 16'hAAAA, 16'h5555, 8'hAA});
    // full-scale jumps: only one turn of correction applies
    send_frame(FUNC_STATUS, {16'h8000, 16'h5555, 16'hAAAA, 8'h55});
    send_frame(FUNC_STATUS, {16'h7FFF, 16'h7FFF, 16'h8000, 8'h7F});
    send_frame(FUNC_ABS, {32'h7FFFFFFF, 16'h7FFF, 8'hAA});
    send_frame(FUNC_ABS, {32'h80000000, 16'h8000, 8'h55});
    send_frame(FUNC_ABS, {32'hFFFFFFFF, 16'hFFFF, 8'h00});
    send_frame(FUNC_ZERO, 56'({$urandom, $urandom}));
    send_frame(FUNC_RSVD, 56'({$urandom, $urandom}));
    send_frame(FUNC_STATUS, {16'h8000, 16'h8000, 16'h7FFF, 8'h80});
    send_frame(FUNC_ZERO, 56'h0);
    send_frame(FUNC_STATUS, {16'h8010, 16'h0123, 16'hFEDC, 8'h3C});

    // Random phases, one gear setting each
    for (int p = 0; p < 6; p++) begin
      wait_drain();
      write_gear(gear_plan[p]);
      steady   = (p == 2 || p == 4);
      hold_req = (p == 4);
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        if (i == 140) steady = 1'b0;
        pick = $urandom_range(99);
        if (pick < 70) begin
          // mostly small or boundary steps so the position keeps tracking
          case ($urandom_range(3))
            0: next_angle = 16'($urandom);
            1: begin
              jump = $urandom_range(4100, 4090);
              if ($urandom_range(1) == 1) jump = -jump;
              next_angle = sent_angle + 16'(jump);
            end
            default: next_angle = sent_angle + 16'($urandom_range(600) - 300);
          endcase
          send_frame(FUNC_STATUS, {next_angle, 16'($urandom), 16'($urandom), 8'($urandom)});
        end else if (pick < 85) begin
          send_frame(FUNC_ABS, {$urandom, 16'($urandom), 8'($urandom)});
        end else if (pick < 93) begin
          send_frame(FUNC_ZERO, 56'({$urandom, $urandom}));
        end else begin
          send_frame(FUNC_RSVD, 56'({$urandom, $urandom}));
        end
      end
    end

    wait_drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d frames (%0d status) under %0d gear writes; %0d results checked.",
             frames_sent, book.status_frames, gear_writes, book.checked);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> motor_feedback_angle_unwrapper_top.f
design/fmau_pkg.sv
design/fmau_front.sv
design/fmau_fifo.sv
design/fmau_back.sv
design/motor_feedback_angle_unwrapper_top.sv
tb/sv/tb.sv
